>>> rtl/ttlet_pkg.sv
// Shared types and constants for the TTL entry table with stale reuse.
`default_nettype none
package ttlet_pkg;

    localparam int CLUSTERS_DEF = 4;
    localparam int BUCKETS_DEF  = 4096;

    localparam int TTL_W  = 31;
    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRESH_TTL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_WIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIMING_TTL = 2'd2;

    typedef enum logic [1:0] {
        ST_HIT   = 2'd0,
        ST_STALE = 2'd1,
        ST_MISS  = 2'd2,
        ST_WROTE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    // one stored record, 88 bits
    typedef struct packed {
        logic [7:0]        state;
        logic [15:0]       server;
        logic [7:0]        volume;
        logic [15:0]       backup_server;
        logic [7:0]        backup_volume;
        logic [TIME_W-1:0] expiry;
    } t_rec;

    // decision handed from the evaluation logic to the control
    typedef struct packed {
        t_status status;
        logic    wr_en;
        logic    hit;
        t_rec    wr_rec;
    } t_eval;

endpackage
`default_nettype wire

>>> rtl/ttl_entry_table_stale_reuse_core.sv
// Top level: TTL record table with stale-reuse, control FSM and output register.
//
//  channel | dir | handshake                    | payload
//  --------+-----+------------------------------+-------------------------------------
//  in      | in  | i_in_valid / o_in_ready      | i_action, i_cluster_index, ... new_*
//  out     | out | o_out_valid / i_out_ready    | o_status, o_rec_*
//  cfg     | in  | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_wdata
//
// A request is accepted together with the memory read, then evaluated and written back
// into the output register; the registered read port of the store sets this order.
// After reset the store is cleared one entry a cycle, all CLUSTERS*BUCKETS entries
// (16384 at defaults), with o_in_ready low; config writes are taken meanwhile.
// A full output register stalls the request in the evaluate step.
`default_nettype none
module ttl_entry_table_stale_reuse_core #(
    parameter int CLUSTERS = ttlet_pkg::CLUSTERS_DEF,
    parameter int BUCKETS  = ttlet_pkg::BUCKETS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [ttlet_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [ttlet_pkg::TTL_W-1:0]        i_cfg_wdata,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_action,
    input  wire [1:0]                         i_cluster_index,
    input  wire [11:0]                        i_bucket_index,
    input  wire [31:0]                        i_now_seconds,
    input  wire [7:0]                         i_new_state,
    input  wire [15:0]                        i_new_server,
    input  wire [7:0]                         i_new_volume,
    input  wire [15:0]                        i_new_backup_server,
    input  wire [7:0]                         i_new_backup_volume,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic [1:0]                        o_status,
    output logic [7:0]                        o_rec_state,
    output logic [15:0]                       o_rec_server,
    output logic [7:0]                        o_rec_volume,
    output logic [15:0]                       o_rec_backup_server,
    output logic [7:0]                        o_rec_backup_volume
);

    localparam int DEPTH = CLUSTERS * BUCKETS;
    localparam int AW    = $clog2(DEPTH);

    ttlet_pkg::t_state r_state, n_state;

    logic [ttlet_pkg::TTL_W-1:0] r_fresh_ttl, r_stale_win, r_priming_ttl;
    logic [AW-1:0]               r_clr_addr, n_clr_addr;

    // held request
    logic                          r_action;
    logic                          r_oob;
    logic [AW-1:0]                 r_addr;
    logic [ttlet_pkg::TIME_W-1:0]  r_now;
    ttlet_pkg::t_rec               r_new_rec;

    logic                          r_out_valid;
    logic [1:0]                    r_out_status;
    ttlet_pkg::t_rec               r_out_rec;

    logic                          in_accept;
    logic                          out_load;
    logic                          mem_rd_en;
    logic                          mem_wr_en;
    logic [AW-1:0]                 mem_wr_addr;
    ttlet_pkg::t_rec               mem_wr_data;
    ttlet_pkg::t_rec               mem_rd_data;
    ttlet_pkg::t_eval              eval;
    logic [AW-1:0]                 req_addr;
    logic                          req_oob;
    logic                          out_free;

    assign req_addr = AW'(i_cluster_index) * AW'(BUCKETS) + AW'(i_bucket_index);
    assign req_oob  = (32'(i_cluster_index) >= 32'(CLUSTERS))
                   || (32'(i_bucket_index) >= 32'(BUCKETS));
    assign out_free = !r_out_valid || i_out_ready;
    assign in_accept = i_in_valid && o_in_ready;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh_ttl   <= '0;
            r_stale_win   <= '0;
            r_priming_ttl <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ttlet_pkg::CFG_FRESH_TTL:   r_fresh_ttl   <= i_cfg_wdata;
                ttlet_pkg::CFG_STALE_WIN:   r_stale_win   <= i_cfg_wdata;
                ttlet_pkg::CFG_PRIMING_TTL: r_priming_ttl <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            ttlet_pkg::S_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ttlet_pkg::S_IDLE;
                end
            end
            ttlet_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ttlet_pkg::S_EVAL;
                end
            end
            ttlet_pkg::S_EVAL: begin
                if (out_free) begin
                    n_state = ttlet_pkg::S_IDLE;
                end
            end
            default: n_state = ttlet_pkg::S_IDLE;
        endcase
    end

    // outputs of the FSM
    always_comb begin
        o_in_ready  = 1'b0;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = r_addr;
        mem_wr_data = eval.wr_rec;
        out_load    = 1'b0;
        case (r_state)
            ttlet_pkg::S_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_addr;
                mem_wr_data = '0;
            end
            ttlet_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                mem_rd_en  = i_in_valid;
            end
            ttlet_pkg::S_EVAL: begin
                out_load  = out_free;
                mem_wr_en = out_free && eval.wr_en;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ttlet_pkg::S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action                <= i_action;
            r_oob                   <= req_oob;
            r_addr                  <= req_addr;
            r_now                   <= i_now_seconds;
            r_new_rec.state         <= i_new_state;
            r_new_rec.server        <= i_new_server;
            r_new_rec.volume        <= i_new_volume;
            r_new_rec.backup_server <= i_new_backup_server;
            r_new_rec.backup_volume <= i_new_backup_volume;
            r_new_rec.expiry        <= '0;
        end
    end

    ttlet_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (req_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    ttlet_eval u_eval (
        .i_action      (r_action),
        .i_oob         (r_oob),
        .i_now         (r_now),
        .i_new_rec     (r_new_rec),
        .i_rd_rec      (mem_rd_data),
        .i_fresh_ttl   (r_fresh_ttl),
        .i_stale_win   (r_stale_win),
        .i_priming_ttl (r_priming_ttl),
        .o_eval        (eval)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= eval.status;
            r_out_rec    <= eval.hit ? mem_rd_data : '0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_out_status;
    assign o_rec_state         = r_out_rec.state;
    assign o_rec_server        = r_out_rec.server;
    assign o_rec_volume        = r_out_rec.volume;
    assign o_rec_backup_server = r_out_rec.backup_server;
    assign o_rec_backup_volume = r_out_rec.backup_volume;

    // no store write while waiting for a request
    a_no_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_wr_en && r_state == ttlet_pkg::S_IDLE))
        else $error("store written while idle");

    // an accepted request is evaluated in the next cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == ttlet_pkg::S_EVAL)
        else $error("accepted request not evaluated");

    // record fields are zero on anything but a hit
    a_zero_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != 2'(ttlet_pkg::ST_HIT)) |->
        (o_rec_state == '0 && o_rec_server == '0 && o_rec_volume == '0
         && o_rec_backup_server == '0 && o_rec_backup_volume == '0))
        else $error("record fields not zero on miss");

    // a result is loaded only from the evaluate step
    a_load_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> r_state == ttlet_pkg::S_EVAL)
        else $error("result loaded outside evaluate step");

endmodule
`default_nettype wire

>>> rtl/ttlet_mem.sv
// Record store: single write port, one registered read port.
`default_nettype none
module ttlet_mem #(
    parameter int DEPTH = ttlet_pkg::CLUSTERS_DEF * ttlet_pkg::BUCKETS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                  i_clk,
    input  wire                  i_rd_en,
    input  wire [AW-1:0]         i_rd_addr,
    output ttlet_pkg::t_rec      o_rd_data,
    input  wire                  i_wr_en,
    input  wire [AW-1:0]         i_wr_addr,
    input  wire ttlet_pkg::t_rec i_wr_data
);

    ttlet_pkg::t_rec r_mem [DEPTH];
    ttlet_pkg::t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

>>> rtl/ttlet_eval.sv
// Freshness check and write-back record for one request.
`default_nettype none
module ttlet_eval (
    input  wire                              i_action,
    input  wire                              i_oob,
    input  wire [ttlet_pkg::TIME_W-1:0]      i_now,
    input  wire ttlet_pkg::t_rec             i_new_rec,
    input  wire ttlet_pkg::t_rec             i_rd_rec,
    input  wire [ttlet_pkg::TTL_W-1:0]       i_fresh_ttl,
    input  wire [ttlet_pkg::TTL_W-1:0]      i_stale_win,
    input  wire [ttlet_pkg::TTL_W-1:0]      i_priming_ttl,
    output ttlet_pkg::t_eval                 o_eval
);

    logic [ttlet_pkg::TIME_W-1:0] diff;
    logic                         expired;
    logic                         in_window;

    // signed age past expiry, modulo 2^32
    assign diff      = i_now - i_rd_rec.expiry;
    assign expired   = (diff != '0) && !diff[ttlet_pkg::TIME_W-1];
    assign in_window = diff < {1'b0, i_stale_win};

    always_comb begin
        o_eval        = '0;
        o_eval.status = ttlet_pkg::ST_MISS;
        if (i_oob) begin
            o_eval.status = ttlet_pkg::ST_MISS;
        end else if (i_action) begin
            o_eval.status        = ttlet_pkg::ST_WROTE;
            o_eval.wr_en         = 1'b1;
            o_eval.wr_rec        = i_new_rec;
            o_eval.wr_rec.expiry = i_now + {1'b0, i_fresh_ttl};
        end else if (expired && in_window) begin
            o_eval.status        = ttlet_pkg::ST_STALE;
            o_eval.wr_en         = 1'b1;
            o_eval.wr_rec        = i_rd_rec;
            o_eval.wr_rec.expiry = i_now + {1'b0, i_priming_ttl};
        end else if (expired) begin
            o_eval.status = ttlet_pkg::ST_MISS;
        end else begin
            o_eval.status = ttlet_pkg::ST_HIT;
            o_eval.hit    = 1'b1;
        end
    end

endmodule
`default_nettype wire

>>> sim/ttl_entry_table_stale_reuse_core_test.sv
// Self-checking testbench for the TTL record table with stale reuse: directed and random traffic, scoreboard.
`timescale 1ns / 1ps
module ttl_entry_table_stale_reuse_core_test;

    localparam logic                          ACT_LOOKUP     = 1'b0;
    localparam logic                          ACT_WRITE      = 1'b1;
    localparam logic [ttlet_pkg::TTL_W-1:0]   TTL_MAX        = '1;
    localparam int                            TABLE_DEPTH    =
        ttlet_pkg::CLUSTERS_DEF * ttlet_pkg::BUCKETS_DEF;
    localparam int                            WATCHDOG_LIMIT = 60000;  // clear pass covers all 16384 entries
    localparam int                            RX_HOLD_CYCLES = 300;
    localparam int                            HOT_ENTRIES    = 6;

    typedef struct packed {
        logic        action;
        logic [1:0]  cluster;
        logic [11:0] bucket;
        logic [31:0] now;
        logic [7:0]  state;
        logic [15:0] server;
        logic [7:0]  volume;
        logic [15:0] backup_server;
        logic [7:0]  backup_volume;
    } t_req;

    typedef struct packed {
        ttlet_pkg::t_status status;
        logic [7:0]         state;
        logic [15:0]        server;
        logic [7:0]         volume;
        logic [15:0]        backup_server;
        logic [7:0]         backup_volume;
    } t_reply;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             cfg_we;
    logic [ttlet_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [ttlet_pkg::TTL_W-1:0]      cfg_wdata;
    logic                             in_valid;
    logic                             out_ready;
    t_req                             cur_req;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [1:0]            o_status;
    logic [7:0]            o_rec_state;
    logic [15:0]           o_rec_server;
    logic [7:0]            o_rec_volume;
    logic [15:0]           o_rec_backup_server;
    logic [7:0]            o_rec_backup_volume;

    // mirror of the table and its registers
    ttlet_pkg::t_rec                  rec_tbl [0:TABLE_DEPTH-1];
    logic [ttlet_pkg::TTL_W-1:0]      fresh_ttl;
    logic [ttlet_pkg::TTL_W-1:0]      stale_win;
    logic [ttlet_pkg::TTL_W-1:0]      priming_ttl;

    t_req                  request_backlog [$];
    t_reply                expected_replies [$];
    int                    mismatches;
    int                    idle_cycles;

    logic                  req_took;
    logic                  reply_took;
    logic                  send_burst;
    logic                  recv_burst;
    int                    send_gap;
    int                    recv_stall;
    logic                  hold_req;
    int                    hold_left;

    logic [1:0]            hot_cl [HOT_ENTRIES];
    logic [11:0]           hot_bk [HOT_ENTRIES];
    logic [31:0]           t_base;

    ttl_entry_table_stale_reuse_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_idx           (cfg_idx),
        .i_cfg_wdata         (cfg_wdata),
        .i_in_valid          (in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (cur_req.action),
        .i_cluster_index     (cur_req.cluster),
        .i_bucket_index      (cur_req.bucket),
        .i_now_seconds       (cur_req.now),
        .i_new_state         (cur_req.state),
        .i_new_server        (cur_req.server),
        .i_new_volume        (cur_req.volume),
        .i_new_backup_server (cur_req.backup_server),
        .i_new_backup_volume (cur_req.backup_volume),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (out_ready),
        .o_status            (o_status),
        .o_rec_state         (o_rec_state),
        .o_rec_server        (o_rec_server),
        .o_rec_volume        (o_rec_volume),
        .o_rec_backup_server (o_rec_backup_server),
        .o_rec_backup_volume (o_rec_backup_volume)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Applies one request to the mirror table and returns the reply it should produce.
    function automatic t_reply apply_request(t_req r);
        t_reply          rep;
        ttlet_pkg::t_rec rec;
        logic [13:0]     addr;
        logic [31:0]     age;
        rep  = '0;
        addr = {r.cluster, r.bucket};
        rec  = rec_tbl[addr];
        if (r.action == ACT_WRITE) begin
            rec.state         = r.state;
            rec.server        = r.server;
            rec.volume        = r.volume;
            rec.backup_server = r.backup_server;
            rec.backup_volume = r.backup_volume;
            rec.expiry        = r.now + {1'b0, fresh_ttl};
            rec_tbl[addr]     = rec;
            rep.status        = ttlet_pkg::ST_WROTE;
        end else begin
            // signed age past expiry; exactly -2^31 still counts as fresh
            age = r.now - rec.expiry;
            if (age != 32'd0 && !age[31]) begin
                if (age < {1'b0, stale_win}) begin
                    rec.expiry    = r.now + {1'b0, priming_ttl};
                    rec_tbl[addr] = rec;
                    rep.status    = ttlet_pkg::ST_STALE;
                end else begin
                    rep.status = ttlet_pkg::ST_MISS;
                end
            end else begin
                rep.status        = ttlet_pkg::ST_HIT;
                rep.state         = rec.state;
                rep.server        = rec.server;
                rep.volume        = rec.volume;
                rep.backup_server = rec.backup_server;
                rep.backup_volume = rec.backup_volume;
            end
        end
        return rep;
    endfunction

    function automatic t_req make_req(logic act, logic [1:0] cl, logic [11:0] bk,
                                      logic [31:0] now, logic [15:0] fill);
        t_req r;
        r.action        = act;
        r.cluster       = cl;
        r.bucket        = bk;
        r.now           = now;
        r.state         = fill[7:0];
        r.server        = fill;
        r.volume        = fill[15:8];
        r.backup_server = ~fill;
        r.backup_volume = ~fill[7:0];
        return r;
    endfunction

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
        end
    endtask

    // request side: scoreboard update on accept, reply check on output handshake
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                expected_replies.push_back(apply_request(cur_req));
                req_took = 1'b1;
            end
            if (o_out_valid && out_ready) begin
                reply_took = 1'b1;
                if (expected_replies.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected reply, expected none, got status %0d",
                             $time, o_status);
                end else begin
                    want = expected_replies.pop_front();
                    check_field("status",            want.status,        o_status);
                    check_field("rec_state",         want.state,         o_rec_state);
                    check_field("rec_server",        want.server,        o_rec_server);
                    check_field("rec_volume",        want.volume,        o_rec_volume);
                    check_field("rec_backup_server", want.backup_server,
                                o_rec_backup_server);
                    check_field("rec_backup_volume", want.backup_volume,
                                o_rec_backup_volume);
                end
            end
        end
    end

    // driver: one request at a time from the backlog, random gap after each accept
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (req_took) begin
                req_took = 1'b0;
                in_valid = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 14);
            end
            if (!in_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (request_backlog.size() != 0) begin
                    cur_req  = request_backlog.pop_front();
                    in_valid = 1'b1;
                end
            end
        end
    end

    // reply side backpressure, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready = 1'b0;
        end else begin
            if (reply_took) begin
                reply_took = 1'b0;
                if ($urandom_range(0, 31) == 0)
                    recv_burst = !recv_burst;
                recv_stall = recv_burst ? 0 : $urandom_range(0, 14);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ready = 1'b0;
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, idle_cycles);
                $display("** ttl_entry_table_stale_reuse_core: FAILED **");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [ttlet_pkg::CFG_IDX_W-1:0] idx,
                             logic [ttlet_pkg::TTL_W-1:0] val);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_idx   = idx;
        cfg_wdata = val;
        @(negedge i_clk);
        cfg_we    = 1'b0;
    endtask

    // only called with nothing in flight
    task automatic set_config(logic [ttlet_pkg::TTL_W-1:0] f, logic [ttlet_pkg::TTL_W-1:0] w,
                              logic [ttlet_pkg::TTL_W-1:0] p);
        write_reg(ttlet_pkg::CFG_FRESH_TTL, f);
        write_reg(ttlet_pkg::CFG_STALE_WIN, w);
        write_reg(ttlet_pkg::CFG_PRIMING_TTL, p);
        fresh_ttl   = f;
        stale_win   = w;
        priming_ttl = p;
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (request_backlog.size() != 0 || in_valid || expected_replies.size() != 0);
    endtask

    task automatic refresh_hot_set();
        for (int k = 0; k < HOT_ENTRIES; k++) begin
            hot_cl[k] = 2'($urandom_range(0, 3));
            hot_bk[k] = 12'($urandom_range(0, 4095));
        end
        t_base = $urandom;
    endtask

    // Mostly lookups and writes on a few hot records with time creeping forward, so that
    // records pass through fresh, stale and expired; the rest is scattered noise.
    task automatic add_random(int count, int unsigned step_max);
        t_req r;
        int   k;
        for (int n = 0; n < count; n++) begin
            r.action = ($urandom_range(0, 99) < 30) ? ACT_WRITE : ACT_LOOKUP;
            if ($urandom_range(0, 9) == 0) begin
                r.cluster = 2'($urandom_range(0, 3));
                r.bucket  = 12'($urandom_range(0, 4095));
            end else begin
                k         = $urandom_range(0, HOT_ENTRIES - 1);
                r.cluster = hot_cl[k];
                r.bucket  = hot_bk[k];
            end
            if ($urandom_range(0, 15) == 0)
                t_base = $urandom;
            else
                t_base = t_base + $urandom_range(0, step_max);
            r.now = t_base;
            if ($urandom_range(0, 7) == 0)
                r.now = t_base - $urandom_range(0, step_max);
            r.state         = 8'($urandom_range(0, 255));
            r.server        = 16'($urandom_range(0, 65535));
            r.volume        = 8'($urandom_range(0, 255));
            r.backup_server = 16'($urandom_range(0, 65535));
            r.backup_volume = 8'($urandom_range(0, 255));
            request_backlog.push_back(r);
        end
    endtask

    initial begin
        logic [ttlet_pkg::TTL_W-1:0] f;
        logic [ttlet_pkg::TTL_W-1:0] w;
        logic [ttlet_pkg::TTL_W-1:0] p;
        int unsigned                 step;

        i_rst_n     = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = ttlet_pkg::CFG_FRESH_TTL;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        cur_req     = '0;
        req_took    = 1'b0;
        reply_took  = 1'b0;
        send_burst  = 1'b0;
        recv_burst  = 1'b0;
        send_gap    = 0;
        recv_stall  = 0;
        hold_req    = 1'b0;
        hold_left   = 0;
        mismatches  = 0;
        idle_cycles = 0;
        fresh_ttl   = '0;
        stale_win   = '0;
        priming_ttl = '0;
        t_base      = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            rec_tbl[i] = '0;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: boundaries of the freshness test, wraparound, untouched records
        set_config(31'd100, 31'd50, 31'd10);
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd0, 12'd0, 32'd0, 16'h0));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd0, 12'd1, 32'd5, 16'h0));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd0, 12'd1, 32'd10, 16'h0));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd0, 12'd1, 32'd16, 16'h0));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd0, 12'd2, 32'h8000_0000, 16'h0));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd0, 12'd3, 32'h7FFF_FFFF, 16'h0));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd0, 12'd4, 32'd50, 16'h0));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd0, 12'd5, 32'd49, 16'h0));
        request_backlog.push_back(make_req(ACT_WRITE, 2'd3, 12'hFFF, 32'hFFFF_FFF0, 16'hFFFF));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd3, 12'hFFF, 32'h54, 16'h0));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd3, 12'hFFF, 32'h55, 16'h0));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd3, 12'hFFF, 32'h5F, 16'h0));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd3, 12'hFFF, 32'h5F + 50, 16'h0));
        request_backlog.push_back(make_req(ACT_WRITE, 2'd2, 12'hAAA, 32'hAAAA_AAAA, 16'hAAAA));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd2, 12'hAAA, 32'hAAAA_AAAA + 100,
                                           16'h0));
        request_backlog.push_back(make_req(ACT_WRITE, 2'd1, 12'h555, 32'h5555_5555, 16'h5555));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd1, 12'h555, 32'h5555_5555 + 101,
                                           16'h0));
        request_backlog.push_back(make_req(ACT_WRITE, 2'd0, 12'd0, 32'd0, 16'h0000));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd0, 12'd0, 32'hFFFF_FFFF, 16'h0));
        request_backlog.push_back(make_req(ACT_LOOKUP, 2'd0, 12'd0, 32'h8000_0064, 16'h0));
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin f = '0;      w = '0;      p = '0;      step = 3;            end
                1: begin f = TTL_MAX; w = TTL_MAX; p = TTL_MAX; step = 32'h4000_0000; end
                2: begin f = 31'd20;  w = 31'd10;  p = 31'd5;   step = 8;            end
                3: begin f = 31'd5;   w = 31'd40;  p = '0;      step = 6;            end
                4: begin f = '0;      w = TTL_MAX; p = 31'd3;   step = 4;            end
                5: begin f = TTL_MAX; w = '0;      p = TTL_MAX; step = 32'h3000_0000; end
                default: begin
                    f    = 31'($urandom_range(0, 60));
                    w    = 31'($urandom_range(0, 60));
                    p    = 31'($urandom_range(0, 60));
                    step = 16;
                end
            endcase
            set_config(f, w, p);
            refresh_hot_set();
            // long reply hold-off while requests keep coming: fills the pipe
            if (ph == 1 || ph == 3)
                hold_req = 1'b1;
            add_random(110, step);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        mismatches += expected_replies.size();
        if (mismatches == 0)
            $display("** ttl_entry_table_stale_reuse_core: PASSED **");
        else
            $display("** ttl_entry_table_stale_reuse_core: FAILED **");
        $finish;
    end

endmodule
